>>> sv/ctf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared types, constants and helper functions of the transfer-function unit.
// ----------------------------------------------------------------------------
package ctf_pkg;

    // Fixed-point format of the component words
    localparam int CTF_FRAC = 16;
    localparam int CTF_VW   = CTF_FRAC + 1;
    localparam int CTF_QSH  = 32 - CTF_FRAC;
    localparam logic [CTF_VW-1:0] CTF_ONE = {1'b1, {CTF_FRAC{1'b0}}};

    // Curve select codes
    typedef enum logic [1:0] {
        OP_SRGB_ENC = 2'd0,
        OP_SRGB_DEC = 2'd1,
        OP_ROMM_ENC = 2'd2,
        OP_ROMM_DEC = 2'd3
    } t_op;

    // Knees as largest input that still takes the linear segment
    localparam longint unsigned KNEE_SE_L = (64'd3928 << CTF_FRAC) / 64'd1292000;
    localparam longint unsigned KNEE_SD_L = (64'd3928 << CTF_FRAC) / 64'd100000;
    localparam longint unsigned KNEE_RE_L = (64'd1953 << CTF_FRAC) / 64'd1000000;
    localparam longint unsigned KNEE_RD_L = (64'd31248 << CTF_FRAC) / 64'd1000000;
    localparam logic [CTF_VW-1:0] CTF_KNEE_SE = CTF_VW'(KNEE_SE_L);
    localparam logic [CTF_VW-1:0] CTF_KNEE_SD = CTF_VW'(KNEE_SD_L);
    localparam logic [CTF_VW-1:0] CTF_KNEE_RE = CTF_VW'(KNEE_RE_L);
    localparam logic [CTF_VW-1:0] CTF_KNEE_RD = CTF_VW'(KNEE_RD_L);

    // Reciprocals for exact floor division by small constants
    localparam int CTF_R100_SH  = 25;
    localparam int CTF_R1292_SH = 29;
    localparam int CTF_R1000_SH = 37;
    localparam longint unsigned R100_L  = ((64'd1 << CTF_R100_SH) + 64'd99) / 64'd100;
    localparam longint unsigned R1292_L = ((64'd1 << CTF_R1292_SH) + 64'd1291) / 64'd1292;
    localparam longint unsigned R1000_L = ((64'd1 << CTF_R1000_SH) + 64'd999) / 64'd1000;
    localparam logic [18:0] CTF_R100  = 19'(R100_L);
    localparam logic [18:0] CTF_R1292 = 19'(R1292_L);
    localparam logic [27:0] CTF_R1000 = 28'(R1000_L);

    // Q32 constants of the sRGB curves
    localparam logic [43:0] CTF_OFF    = 44'd55 << 32;
    localparam logic [43:0] CTF_HALF_D = 44'd1000 << (31 - CTF_FRAC);
    localparam logic [47:0] CTF_DEC_ADD = (48'd55 << 32) + 48'd527;
    localparam logic [10:0] CTF_DEC_DEN = 11'd1055;

    // Sideband that travels with each word
    typedef struct packed {
        t_op              op;
        logic             lin;
        logic [CTF_VW-1:0] lin_val;
    } t_side;

    // One radix-2 chunk of a long division
    typedef struct packed {
        logic [10:0] rem;
        logic [7:0]  quo;
    } t_dstep;

    // Eight restoring-division steps, MSB first
    function automatic t_dstep ctf_div8(input logic [10:0] rem, input logic [7:0] bits,
                                        input logic [10:0] den);
        logic [11:0] r;
        t_dstep      res;
        r = {1'b0, rem};
        res.quo = '0;
        for (int i = 7; i >= 0; i--) begin
            r = {r[10:0], bits[i]};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                res.quo[i] = 1'b1;
            end
        end
        res.rem = r[10:0];
        return res;
    endfunction

    // Floor integer square root, elaboration use only
    function automatic logic [63:0] ctf_isqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        b = 64'd1 << 62;
        x = n;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q32 factor 2^(-2^-k), by repeated square roots from sqrt(0.5)
    function automatic logic [31:0] ctf_tab(input int k);
        logic [63:0] t;
        t = ctf_isqrt(64'd1 << 63);
        for (int i = 2; i <= k; i++) begin
            t = ctf_isqrt(t << 32);
        end
        return t[31:0];
    endfunction

    // Exponent ratio of each curve
    function automatic logic [3:0] ctf_pow_num(input t_op op);
        logic [3:0] v;
        unique case (op)
            OP_SRGB_ENC: v = 4'd5;
            OP_SRGB_DEC: v = 4'd12;
            OP_ROMM_ENC: v = 4'd5;
            OP_ROMM_DEC: v = 4'd9;
            default:     v = 4'd5;
        endcase
        return v;
    endfunction

    function automatic logic [10:0] ctf_pow_den(input t_op op);
        logic [10:0] v;
        unique case (op)
            OP_SRGB_ENC: v = 11'd12;
            OP_SRGB_DEC: v = 11'd5;
            OP_ROMM_ENC: v = 11'd9;
            OP_ROMM_DEC: v = 11'd5;
            default:     v = 11'd5;
        endcase
        return v;
    endfunction

endpackage

>>> sv/ctf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_div
// Pipelined long divider: 48-bit dividend, 11-bit divisor, eight quotient
// bits per stage over six stages.
// ----------------------------------------------------------------------------
module ctf_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  ctf_pkg::t_side i_side,
    input  logic [47:0]    i_num,
    input  logic [10:0]    i_den,
    output logic           o_vld,
    output ctf_pkg::t_side o_side,
    output logic [47:0]    o_quo
);
    import ctf_pkg::*;

    logic        r_vld  [0:5];
    t_side       r_side [0:5];
    logic [47:0] r_w    [0:5];
    logic [10:0] r_rem  [0:5];
    logic [10:0] r_den  [0:5];

    for (genvar g = 0; g < 6; g++) begin : g_stage
        logic        pv;
        t_side       ps;
        logic [47:0] pw;
        logic [10:0] prm;
        logic [10:0] pd;
        t_dstep      n_step;
        logic [47:0] n_w;

        if (g == 0) begin : g_first
            assign pv  = i_vld;
            assign ps  = i_side;
            assign pw  = i_num;
            assign prm = '0;
            assign pd  = i_den;
        end else begin : g_next
            assign pv  = r_vld[g-1];
            assign ps  = r_side[g-1];
            assign pw  = r_w[g-1];
            assign prm = r_rem[g-1];
            assign pd  = r_den[g-1];
        end

        // dividend bits are replaced by quotient bits in place
        assign n_step = ctf_div8(prm, pw[47-8*g -: 8], pd);
        always_comb begin
            n_w = pw;
            n_w[47-8*g -: 8] = n_step.quo;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= ps;
                r_w[g]    <= n_w;
                r_rem[g]  <= n_step.rem;
                r_den[g]  <= pd;
            end
        end
    end

    assign o_vld  = r_vld[5];
    assign o_side = r_side[5];
    assign o_quo  = r_w[5];

endmodule

>>> sv/ctf_pow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_pow
// Fixed-point power x^(num/den) on a Q32 base: -log2 by 30 squaring stages,
// exponent scaling through a long divider, then 2^-E by 30 stages of
// constant square-root factors and a rounding shift.
// ----------------------------------------------------------------------------
module ctf_pow (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  ctf_pkg::t_side i_side,
    input  logic [32:0]    i_u,
    output logic           o_vld,
    output ctf_pkg::t_side o_side,
    output logic [32:0]    o_p
);
    import ctf_pkg::*;

    // ---------------- leading-one search ----------------
    logic        r_lz_vld;
    t_side       r_lz_side;
    logic [32:0] r_lz_u;
    logic [5:0]  r_lz_p;
    logic [5:0]  n_lz_p;

    always_comb begin
        n_lz_p = '0;
        for (int i = 0; i < 33; i++) begin
            if (i_u[i]) n_lz_p = 6'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lz_vld <= 1'b0;
        end else if (i_en) begin
            r_lz_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lz_side <= i_side;
            r_lz_u    <= i_u;
            r_lz_p    <= n_lz_p;
        end
    end

    // ---------------- normalize mantissa to Q30 ----------------
    logic        r_sq_vld  [0:30];
    t_side       r_sq_side [0:30];
    logic [30:0] r_sq_m    [0:30];
    logic [29:0] r_sq_frac [0:30];
    logic [5:0]  r_sq_p    [0:30];
    logic [63:0] n_nm_wide;

    always_comb begin
        if (r_lz_p >= 6'd30) begin
            n_nm_wide = {31'b0, r_lz_u} >> (r_lz_p - 6'd30);
        end else begin
            n_nm_wide = {31'b0, r_lz_u} << (6'd30 - r_lz_p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_sq_vld[0] <= r_lz_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_side[0] <= r_lz_side;
            r_sq_m[0]    <= n_nm_wide[30:0];
            r_sq_frac[0] <= '0;
            r_sq_p[0]    <= r_lz_p;
        end
    end

    // ---------------- one log bit per squaring stage ----------------
    for (genvar g = 1; g <= 30; g++) begin : g_sq
        logic [61:0] n_sq;
        logic [31:0] n_t;
        logic [30:0] n_m;
        logic [29:0] n_frac;

        assign n_sq = 62'(r_sq_m[g-1]) * 62'(r_sq_m[g-1]);
        assign n_t  = n_sq[61:30];

        always_comb begin
            n_frac = r_sq_frac[g-1];
            if (n_t[31]) begin
                n_m = n_t[31:1];
                n_frac[30-g] = 1'b1;
            end else begin
                n_m = n_t[30:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_sq_vld[g] <= r_sq_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_side[g] <= r_sq_side[g-1];
                r_sq_m[g]    <= n_m;
                r_sq_frac[g] <= n_frac;
                r_sq_p[g]    <= r_sq_p[g-1];
            end
        end
    end

    // ---------------- -log2 times exponent numerator ----------------
    logic        r_nm_vld;
    t_side       r_nm_side;
    logic [47:0] r_nm_num;
    logic [10:0] r_nm_den;
    logic [35:0] n_log;
    logic [10:0] n_pden;
    logic [47:0] n_scaled;

    assign n_log    = {6'd32 - r_sq_p[30], 30'b0} - {6'b0, r_sq_frac[30]};
    assign n_pden   = ctf_pow_den(r_sq_side[30].op);
    assign n_scaled = 48'(n_log) * 48'(ctf_pow_num(r_sq_side[30].op))
                    + 48'(n_pden >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_vld <= 1'b0;
        end else if (i_en) begin
            r_nm_vld <= r_sq_vld[30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nm_side <= r_sq_side[30];
            r_nm_num  <= n_scaled;
            r_nm_den  <= n_pden;
        end
    end

    // ---------------- E = round(L * num / den) ----------------
    logic        e_vld;
    t_side       e_side;
    logic [47:0] e_quo;

    ctf_div u_ediv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r_nm_vld),
        .i_side  (r_nm_side),
        .i_num   (r_nm_num),
        .i_den   (r_nm_den),
        .o_vld   (e_vld),
        .o_side  (e_side),
        .o_quo   (e_quo)
    );

    // ---------------- 2^-frac(E) product chain ----------------
    logic        r_ex_vld  [1:30];
    t_side       r_ex_side [1:30];
    logic [32:0] r_ex_acc  [1:30];
    logic [29:0] r_ex_f    [1:30];
    logic [5:0]  r_ex_ip   [1:30];
    logic        r_ex_big  [1:30];

    for (genvar k = 1; k <= 30; k++) begin : g_ex
        localparam logic [31:0] K_TAB = ctf_tab(k);
        logic        pv;
        t_side       ps;
        logic [32:0] pacc;
        logic [29:0] pf;
        logic [5:0]  pip;
        logic        pbig;
        logic [64:0] n_prod;
        logic [32:0] n_acc;

        if (k == 1) begin : g_first
            assign pv   = e_vld;
            assign ps   = e_side;
            assign pacc = 33'd1 << 32;
            assign pf   = e_quo[29:0];
            assign pip  = e_quo[35:30];
            assign pbig = (e_quo[47:30] > 18'd34);
        end else begin : g_next
            assign pv   = r_ex_vld[k-1];
            assign ps   = r_ex_side[k-1];
            assign pacc = r_ex_acc[k-1];
            assign pf   = r_ex_f[k-1];
            assign pip  = r_ex_ip[k-1];
            assign pbig = r_ex_big[k-1];
        end

        assign n_prod = 65'(pacc) * 65'(K_TAB) + (65'd1 << 31);
        assign n_acc  = pf[30-k] ? n_prod[64:32] : pacc;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ex_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_ex_vld[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ex_side[k] <= ps;
                r_ex_acc[k]  <= n_acc;
                r_ex_f[k]    <= pf;
                r_ex_ip[k]   <= pip;
                r_ex_big[k]  <= pbig;
            end
        end
    end

    // ---------------- integer part: rounding right shift ----------------
    logic        r_sh_vld;
    t_side       r_sh_side;
    logic [32:0] r_sh_p;
    logic [34:0] n_sum;
    logic [34:0] n_shr;
    logic [32:0] n_p;

    always_comb begin
        n_sum = '0;
        n_shr = '0;
        if (r_ex_big[30]) begin
            n_p = '0;
        end else if (r_ex_ip[30] == 6'd0) begin
            n_p = r_ex_acc[30];
        end else begin
            n_sum = {2'b0, r_ex_acc[30]} + (35'd1 << (r_ex_ip[30] - 6'd1));
            n_shr = n_sum >> r_ex_ip[30];
            n_p   = n_shr[32:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_vld <= 1'b0;
        end else if (i_en) begin
            r_sh_vld <= r_ex_vld[30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh_side <= r_ex_side[30];
            r_sh_p    <= n_p;
        end
    end

    assign o_vld  = r_sh_vld;
    assign o_side = r_sh_side;
    assign o_p    = r_sh_p;

endmodule

>>> sv/color_transfer_function.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_transfer_function
// Per-component sRGB / ROMM encode and decode curves on Q16 words.
// ----------------------------------------------------------------------------
// One word enters per clock unless the pipeline is held. The depth of the
// pipeline is set by the fixed-point power path: 30 squaring stages for the
// log, 30 multiply stages for the exponential and two six-stage long
// dividers. Linear-segment words ride the same pipeline so order is kept.
// The whole pipeline holds while the output word is stalled; input stall
// is raised only in that case.
// ----------------------------------------------------------------------------
module color_transfer_function (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_op,
    input  logic [ctf_pkg::CTF_VW-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [ctf_pkg::CTF_VW-1:0] o_result
);
    import ctf_pkg::*;

    logic en;

    // output register holds the pipeline when stalled
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // ---------------- input register with saturation ----------------
    logic              r_t0_vld;
    t_op               r_t0_op;
    logic [CTF_VW-1:0] r_t0_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_vld <= 1'b0;
        end else if (en) begin
            r_t0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t0_op <= t_op'(i_op);
            r_t0_v  <= (i_value > CTF_ONE) ? CTF_ONE : i_value;
        end
    end

    // ---------------- knee test, linear numerators, power base ----------------
    logic        r_t1_vld;
    t_op         r_t1_op;
    logic        r_t1_lin;
    logic [17:0] r_t1_pre;
    logic [47:0] r_t1_num;
    logic [10:0] r_t1_den;
    logic        n_lin;
    logic [17:0] n_pre;
    logic [47:0] n_num;
    logic [10:0] n_den;
    logic [11:0] n_v12;

    assign n_v12 = r_t0_v[11:0];

    always_comb begin
        n_num = 48'(r_t0_v) << CTF_QSH;
        n_den = 11'd1;
        unique case (r_t0_op)
            OP_SRGB_ENC: begin
                n_lin = (r_t0_v <= CTF_KNEE_SE);
                n_pre = 18'(r_t0_v[7:0]) * 18'd1292 + 18'd50;
            end
            OP_SRGB_DEC: begin
                n_lin = (r_t0_v <= CTF_KNEE_SD);
                n_pre = 18'(n_v12) * 18'd100 + 18'd646;
                n_num = ((48'(r_t0_v) * 48'd1000) << CTF_QSH) + CTF_DEC_ADD;
                n_den = CTF_DEC_DEN;
            end
            OP_ROMM_ENC: begin
                n_lin = (r_t0_v <= CTF_KNEE_RE);
                n_pre = 18'(r_t0_v[6:0]) << 4;
            end
            OP_ROMM_DEC: begin
                n_lin = (r_t0_v <= CTF_KNEE_RD);
                n_pre = (18'(n_v12) + 18'd8) >> 4;
            end
            default: begin
                n_lin = 1'b0;
                n_pre = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_vld <= 1'b0;
        end else if (en) begin
            r_t1_vld <= r_t0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1_op  <= r_t0_op;
            r_t1_lin <= n_lin;
            r_t1_pre <= n_pre;
            r_t1_num <= n_num;
            r_t1_den <= n_den;
        end
    end

    // ---------------- linear division by reciprocal ----------------
    logic        r_t2_vld;
    t_side       r_t2_side;
    logic [47:0] r_t2_num;
    logic [10:0] r_t2_den;
    logic [36:0] n_p100;
    logic [36:0] n_p1292;
    t_side       n_side;

    assign n_p100  = 37'(r_t1_pre) * 37'(CTF_R100);
    assign n_p1292 = 37'(r_t1_pre) * 37'(CTF_R1292);

    always_comb begin
        n_side.op  = r_t1_op;
        n_side.lin = r_t1_lin;
        case (r_t1_op)
            OP_SRGB_ENC: n_side.lin_val = CTF_VW'(n_p100 >> CTF_R100_SH);
            OP_SRGB_DEC: n_side.lin_val = CTF_VW'(n_p1292 >> CTF_R1292_SH);
            default:     n_side.lin_val = r_t1_pre[CTF_VW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2_vld <= 1'b0;
        end else if (en) begin
            r_t2_vld <= r_t1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t2_side <= n_side;
            r_t2_num  <= r_t1_num;
            r_t2_den  <= r_t1_den;
        end
    end

    // ---------------- Q32 base: sRGB decode divides by 1.055 ----------------
    logic        b_vld;
    t_side       b_side;
    logic [47:0] b_quo;

    ctf_div u_bdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_t2_vld),
        .i_side  (r_t2_side),
        .i_num   (r_t2_num),
        .i_den   (r_t2_den),
        .o_vld   (b_vld),
        .o_side  (b_side),
        .o_quo   (b_quo)
    );

    // ---------------- power ----------------
    logic        p_vld;
    t_side       p_side;
    logic [32:0] p_val;

    ctf_pow u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (b_vld),
        .i_side  (b_side),
        .i_u     (b_quo[32:0]),
        .o_vld   (p_vld),
        .o_side  (p_side),
        .o_p     (p_val)
    );

    // ---------------- output scaling: gain and offset or rounding ----------------
    logic        r_f1_vld;
    t_side       r_f1_side;
    logic [27:0] r_f1_x;
    logic [42:0] n_t;
    logic [43:0] n_y;
    logic [33:0] n_rq;
    logic [27:0] n_x;

    assign n_t  = 43'(p_val) * 43'd1055;
    assign n_y  = 44'(n_t) - CTF_OFF + CTF_HALF_D;
    assign n_rq = (34'(p_val) + (34'd1 << (CTF_QSH - 1))) >> CTF_QSH;

    always_comb begin
        if (p_side.op == OP_SRGB_ENC) begin
            n_x = (44'(n_t) > CTF_OFF) ? 28'(n_y >> CTF_FRAC) : '0;
        end else begin
            n_x = 28'(n_rq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else if (en) begin
            r_f1_vld <= p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_side <= p_side;
            r_f1_x    <= n_x;
        end
    end

    // divide by 1000 via reciprocal
    logic        r_f2_vld;
    t_side       r_f2_side;
    logic [27:0] r_f2_x;
    logic [55:0] r_f2_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_vld <= 1'b0;
        end else if (en) begin
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f2_side <= r_f1_side;
            r_f2_x    <= r_f1_x;
            r_f2_prod <= 56'(r_f1_x) * 56'(CTF_R1000);
        end
    end

    // ---------------- result select and clamp ----------------
    logic              r_f3_vld;
    logic [CTF_VW-1:0] r_f3_res;
    logic [27:0]       n_full;

    always_comb begin
        if (r_f2_side.lin) begin
            n_full = 28'(r_f2_side.lin_val);
        end else if (r_f2_side.op == OP_SRGB_ENC) begin
            n_full = 28'(r_f2_prod >> CTF_R1000_SH);
        end else begin
            n_full = r_f2_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_vld <= 1'b0;
        end else if (en) begin
            r_f3_vld <= r_f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f3_res <= (n_full > 28'(CTF_ONE)) ? CTF_ONE : n_full[CTF_VW-1:0];
        end
    end

    assign o_valid  = r_f3_vld;
    assign o_result = r_f3_res;

endmodule

>>> sv/ctf_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_check
// Port-level checks of the transfer-function unit, bound to the top level.
// ----------------------------------------------------------------------------
module ctf_check (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic [1:0]                 i_op,
    input logic [ctf_pkg::CTF_VW-1:0] i_value,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [ctf_pkg::CTF_VW-1:0] o_result
);
    import ctf_pkg::*;

    // results never exceed 1.0
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result <= CTF_ONE))
        else $error("result above 1.0");

    // input is held back only by a waiting output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output backpressure");

    // a stalled input word stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_op) && $stable(i_value)))
        else $error("stalled input word changed");

    // a stalled output word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result)))
        else $error("stalled output word changed");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid word after reset");

endmodule

bind color_transfer_function ctf_check u_ctf_check (.*);
